// ----- rtl/core/sfr_pkg.sv -----
// sfr_pkg: types, frame constants and the crc-16/modbus byte update
// used by the status frame receiver; the channel interfaces do not import it
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned FRAME_BYTES = 14;
  localparam int unsigned CRC_SPAN    = 12;
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned ADDR_W      = 3;

  localparam logic [IDX_W-1:0] BODY_CRC_END = IDX_W'(CRC_SPAN - 3);
  localparam logic [IDX_W-1:0] BODY_CRC_HI  = IDX_W'(FRAME_BYTES - 5);
  localparam logic [IDX_W-1:0] BODY_LAST    = IDX_W'(FRAME_BYTES - 4);
  localparam logic [IDX_W-1:0] BODY_STORE   = IDX_W'(STORE_DEPTH);

  localparam logic [7:0]  HDR_BYTE  = 8'hFE;
  localparam logic [7:0]  LEN_BYTE  = 8'h0B;
  localparam logic [7:0]  TYPE_BYTE = 8'h25;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_LEN  = 2'd1,
    STAT_TYPE = 2'd2,
    STAT_CRC  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [7:0] vel_x;
    logic signed [7:0] vel_y;
    logic signed [7:0] vel_turn;
    logic [7:0]        motor_state;
    logic [7:0]        motor_fault;
    logic [7:0]        battery_level;
    logic [7:0]        enable_flags;
  } result_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sfr_ifs.sv -----
// sfr channel interfaces: received byte word and decoded result word
// valid/ready handshake, no package dependency
`timescale 1ns / 1ps

interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [7:0] vel_x;
  logic signed [7:0] vel_y;
  logic signed [7:0] vel_turn;
  logic [7:0]        motor_state;
  logic [7:0]        motor_fault;
  logic [7:0]        battery_level;
  logic [7:0]        enable_flags;

  modport source (
    output valid, output status, output vel_x, output vel_y, output vel_turn,
    output motor_state, output motor_fault, output battery_level, output enable_flags,
    input ready
  );
  modport sink (
    input valid, input status, input vel_x, input vel_y, input vel_turn,
    input motor_state, input motor_fault, input battery_level, input enable_flags,
    output ready
  );
endinterface

// ----- rtl/core/status_frame_receiver.sv -----
// status_frame_receiver: parses fixed 14-byte status frames FE FE 0B T .. CH CL
// depends on sfr_pkg and the sfr_rx_if / sfr_res_if interfaces
//
// usage
//   rx_i carries one received serial byte per word. res_o carries one result
//   word per completed frame or per bad length byte: status (ok, bad length,
//   wrong type, crc mismatch) and the raw frame fields, all zero on errors.
//   the crc-16/modbus over the first twelve bytes is updated one byte per
//   cycle, stalls aside, by an unrolled byte-wide xor network, compared
//   big-endian with the last two bytes.
// timing and throughput
//   one byte per cycle unless stalled. a result word is valid in the cycle
//   after the byte that completes it is accepted. parse state and result
//   register update in the same cycle: a byte per cycle unless stalled.
// reset
//   rst_ni clears the parse state to hunting for the first header byte and
//   clears the result valid flag, not the result data. no clearing pass.
// stall
//   while a result word waits and res_o.ready is low, rx_i.ready is low, so
//   no byte is taken until the word leaves.
`timescale 1ns / 1ps

module status_frame_receiver (
  input  logic clk_i,
  input  logic rst_ni,
  sfr_rx_if.sink    rx_i,
  sfr_res_if.source res_o
);
  import sfr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       fb_q [STORE_DEPTH];
  logic [7:0]       crc_hi_q;
  logic             fb_we, crc_hi_we;

  logic             out_valid_q;
  result_t          res_q, res_d;
  logic             res_hit;

  logic             rx_fire;
  logic [7:0]       b;
  logic [15:0]      crc_next;

  assign b         = rx_i.rx_byte;
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_fire   = rx_i.valid && rx_i.ready;
  assign crc_next  = crc_byte(crc_q, b);

  // next state
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    fb_we     = 1'b0;
    crc_hi_we = 1'b0;
    unique case (phase_q)
      PH_HUNT1: begin
        if (b == HDR_BYTE) begin
          crc_d   = crc_byte(CRC_INIT, b);
          phase_d = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (b == HDR_BYTE) begin
          crc_d   = crc_next;
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_HUNT1;
          idx_d   = '0;
          crc_d   = CRC_INIT;
        end
      end
      PH_LEN: begin
        if (b == LEN_BYTE) begin
          crc_d   = crc_next;
          idx_d   = '0;
          phase_d = PH_BODY;
        end else begin
          phase_d = PH_HUNT1;
          idx_d   = '0;
          crc_d   = CRC_INIT;
        end
      end
      PH_BODY: begin
        if (idx_q < BODY_CRC_END) begin
          crc_d = crc_next;
          fb_we = (idx_q < BODY_STORE);
          idx_d = idx_q + 1'b1;
        end else if (idx_q == BODY_CRC_HI) begin
          crc_hi_we = 1'b1;
          idx_d     = idx_q + 1'b1;
        end else begin
          phase_d = PH_HUNT1;
          idx_d   = '0;
          crc_d   = CRC_INIT;
        end
      end
      default: phase_d = PH_HUNT1;
    endcase
  end

  // result word
  always_comb begin
    res_d   = '0;
    res_hit = 1'b0;
    unique case (phase_q)
      PH_LEN: begin
        if (b != LEN_BYTE) begin
          res_hit      = 1'b1;
          res_d.status = STAT_LEN;
        end
      end
      PH_BODY: begin
        if (idx_q >= BODY_LAST) begin
          res_hit = 1'b1;
          if (fb_q[0] != TYPE_BYTE) begin
            res_d.status = STAT_TYPE;
          end else if ({crc_hi_q, b} != crc_q) begin
            res_d.status = STAT_CRC;
          end else begin
            res_d.status        = STAT_OK;
            res_d.vel_x         = fb_q[1];
            res_d.vel_y         = fb_q[2];
            res_d.vel_turn      = fb_q[3];
            res_d.motor_state   = fb_q[4];
            res_d.motor_fault   = fb_q[5];
            res_d.battery_level = fb_q[6];
            res_d.enable_flags  = fb_q[7];
          end
        end
      end
      default: res_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT1;
      idx_q       <= '0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_fire) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        crc_q   <= crc_d;
      end
      if (rx_i.ready) begin
        out_valid_q <= rx_fire && res_hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire && fb_we) begin
      fb_q[idx_q[ADDR_W-1:0]] <= b;
    end
    if (rx_fire && crc_hi_we) begin
      crc_hi_q <= b;
    end
    if (rx_fire && res_hit && rx_i.ready) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = res_q.status;
  assign res_o.vel_x         = res_q.vel_x;
  assign res_o.vel_y         = res_q.vel_y;
  assign res_o.vel_turn      = res_q.vel_turn;
  assign res_o.motor_state   = res_q.motor_state;
  assign res_o.motor_fault   = res_q.motor_fault;
  assign res_o.battery_level = res_q.battery_level;
  assign res_o.enable_flags  = res_q.enable_flags;

  a_idx_only_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (phase_q == PH_BODY))
    else $error("byte index set outside frame body");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (idx_q <= BODY_LAST))
    else $error("byte index past end of frame");

  a_bad_len_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && phase_q == PH_LEN && b != LEN_BYTE)
      |=> (res_o.valid && res_o.status == STAT_LEN))
    else $error("bad length byte without error word");

  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(rx_fire))
    else $error("result word without accepted byte");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != STAT_OK) |->
      (res_o.vel_x == '0 && res_o.enable_flags == '0 && res_o.battery_level == '0))
    else $error("error word carries frame fields");

endmodule
